### sv/msf_pkg.sv
package msf_pkg;
    localparam int PriceBits  = 24;
    localparam int FastPeriod = 12;
    localparam int SlowPeriod = 26;
    localparam int SigPeriod  = 9;
    localparam int FDepth     = FastPeriod + 1;
    localparam int SDepth     = SlowPeriod + 1;
    localparam int PDepth     = (FDepth > SDepth) ? FDepth : SDepth;
    localparam int MDepth     = SigPeriod + 1;
    localparam int HDepth     = (PDepth > MDepth) ? PDepth : MDepth;
    localparam int CntBits    = $clog2(HDepth + 1);
    localparam int WBits      = 18;
    localparam int VBits      = PriceBits + 1;
    localparam int ProdBits   = VBits + WBits;
    localparam int AccBits    = ProdBits + 6;
    localparam int DenBits    = WBits + 6;
    localparam int QBits      = VBits + 1;

    localparam logic [WBits-1:0] WOne = 18'h20000;

    function automatic logic [WBits-1:0] weight(input int period, input int idx);
        logic [63:0] w;
        w = 64'(WOne);
        for (int i = 0; i < 64; i++)
        begin
            if (i < idx)
            begin
                w = (w * 64'(period - 1) + 64'((period + 1) / 2)) / 64'(period + 1);
            end
        end
        return WBits'(w);
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;
endpackage

### sv/msf_cell.sv
// one tap of a window: shifts on load, adds its weighted value to the neighbor's
// partial sum and registers it, so a chain's sum settles register by register after a load
module msf_cell
    import msf_pkg::*;
(
    input  logic                clk,
    input  logic                load,
    input  logic [VBits-1:0]    din,
    output logic [VBits-1:0]    dout,
    input  logic [WBits-1:0]    w,
    input  logic                en,
    input  logic [AccBits-1:0]  acc_in,
    input  logic [DenBits-1:0]  den_in,
    output logic [AccBits-1:0]  acc_out,
    output logic [DenBits-1:0]  den_out
);
    logic [VBits-1:0] val_reg;
    logic [AccBits-1:0] acc_reg;
    logic [DenBits-1:0] den_reg;
    logic [ProdBits-1:0] prod;

    assign prod = ProdBits'(val_reg) * ProdBits'(w);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= din;
        end
        acc_reg <= acc_in + (en ? AccBits'(prod) : '0);
        den_reg <= den_in + (en ? DenBits'(w) : '0);
    end

    assign dout = val_reg;
    assign acc_out = acc_reg;
    assign den_out = den_reg;
endmodule

### sv/msf_div.sv
// restoring divider: q = floor((2*num + den) / (2*den)), one quotient bit per cycle
module msf_div
    import msf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [AccBits-1:0] num,
    input  logic [DenBits-1:0] den,
    output logic               done,
    output logic [QBits-1:0]   quo
);
    localparam int NBits = AccBits + 2;
    localparam int RBits = DenBits + 2;
    localparam int KBits = $clog2(NBits + 1);

    logic [NBits-1:0] n_reg;
    logic [RBits-1:0] r_reg;
    logic [RBits-1:0] d_reg;
    logic [KBits-1:0] k_reg;
    logic             busy_reg;
    logic [RBits-1:0] shifted;

    assign shifted = {r_reg[RBits-2:0], n_reg[NBits-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= KBits'(NBits);
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg - 1'b1;
                if (k_reg == KBits'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= {num, 1'b0} + NBits'(den);
            d_reg <= {1'b0, den, 1'b0};
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= d_reg)
            begin
                r_reg <= shifted - d_reg;
                n_reg <= {n_reg[NBits-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                n_reg <= {n_reg[NBits-2:0], 1'b0};
            end
        end
    end

    assign quo = n_reg[QBits-1:0];
endmodule

### sv/macd_signal_filter.sv
// Sequence: the fast, slow and signal EMAs run in turn for each request. Each of them
//   waits for its tap chain to settle after the last load, then goes through the
//   one-bit-per-cycle divider.
// Throughput: one request at a time; the next is taken the cycle after the result is
//   taken.
// Reset: asynchronous, active low; clears the sample count and control; taps stay unset.
module macd_signal_filter
    import msf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [PriceBits-1:0]        price,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [VBits-1:0]     macd_value,
    output logic signed [VBits-1:0]     signal_value
);
    localparam logic [VBits-1:0] Bias = VBits'(1) << PriceBits;
    localparam logic [1:0] PhFast = 2'd0;
    localparam logic [1:0] PhSlow = 2'd1;
    localparam logic [1:0] PhSig  = 2'd2;

    state_t state_reg;
    logic [1:0] phase_reg;
    logic [CntBits-1:0] seen_reg;
    logic [CntBits-1:0] wait_reg;
    logic pend_reg;
    logic shift_p, shift_m;
    logic [VBits-1:0] fast_reg, slow_reg, macd_new;
    logic div_start, div_done;
    logic [QBits-1:0] quo;

    logic [VBits-1:0]   fv [FDepth+1];
    logic [AccBits-1:0] fa [FDepth+1];
    logic [DenBits-1:0] fd [FDepth+1];
    logic [VBits-1:0]   pv [SDepth+1];
    logic [AccBits-1:0] sa [SDepth+1];
    logic [DenBits-1:0] sd [SDepth+1];
    logic [VBits-1:0]   mv [MDepth+1];
    logic [AccBits-1:0] ma [MDepth+1];
    logic [DenBits-1:0] md [MDepth+1];

    assign fv[0] = {1'b0, price};
    assign pv[0] = {1'b0, price};
    assign fa[0] = '0;
    assign fd[0] = '0;
    assign sa[0] = '0;
    assign sd[0] = '0;
    assign mv[0] = macd_new + Bias;
    assign ma[0] = '0;
    assign md[0] = '0;

    for (genvar i = 0; i < FDepth; i++)
    begin : g_f
        msf_cell u_f (
            .clk(clk), .load(shift_p), .din(fv[i]), .dout(fv[i+1]),
            .w(weight(FastPeriod, i)),
            .en(seen_reg > CntBits'(i)),
            .acc_in(fa[i]), .den_in(fd[i]), .acc_out(fa[i+1]), .den_out(fd[i+1])
        );
    end

    for (genvar i = 0; i < SDepth; i++)
    begin : g_s
        msf_cell u_s (
            .clk(clk), .load(shift_p), .din(pv[i]), .dout(pv[i+1]),
            .w(weight(SlowPeriod, i)),
            .en(seen_reg > CntBits'(i)),
            .acc_in(sa[i]), .den_in(sd[i]), .acc_out(sa[i+1]), .den_out(sd[i+1])
        );
    end

    for (genvar i = 0; i < MDepth; i++)
    begin : g_m
        msf_cell u_m (
            .clk(clk), .load(shift_m), .din(mv[i]), .dout(mv[i+1]),
            .w(weight(SigPeriod, i)),
            .en(seen_reg > CntBits'(i)),
            .acc_in(ma[i]), .den_in(md[i]), .acc_out(ma[i+1]), .den_out(md[i+1])
        );
    end

    logic [AccBits-1:0] dnum;
    logic [DenBits-1:0] dden;
    always_comb
    begin
        case (phase_reg)
            PhFast:  begin dnum = fa[FDepth]; dden = fd[FDepth]; end
            PhSlow:  begin dnum = sa[SDepth]; dden = sd[SDepth]; end
            default: begin dnum = ma[MDepth]; dden = md[MDepth]; end
        endcase
    end

    msf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(dnum), .den(dden),
        .done(div_done), .quo(quo)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign shift_p   = in_valid && in_ready;
    assign shift_m   = div_done && (phase_reg == PhSlow);
    // divider starts once the chains have settled after the last load
    assign div_start = pend_reg && (wait_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PhFast;
            seen_reg  <= '0;
            wait_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (shift_p)
                    begin
                        if (seen_reg < CntBits'(HDepth))
                        begin
                            seen_reg <= seen_reg + 1'b1;
                        end
                        phase_reg <= PhFast;
                        pend_reg  <= 1'b1;
                        wait_reg  <= CntBits'(HDepth);
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (pend_reg)
                    begin
                        if (wait_reg == '0)
                        begin
                            pend_reg <= 1'b0;
                        end
                        else
                        begin
                            wait_reg <= wait_reg - 1'b1;
                        end
                    end
                    else if (div_done)
                    begin
                        if (phase_reg == PhSig)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            phase_reg <= phase_reg + 1'b1;
                            pend_reg  <= 1'b1;
                            wait_reg  <= CntBits'(HDepth);
                        end
                    end
                end
                ST_DONE:
                begin
                    if (out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            case (phase_reg)
                PhFast:  fast_reg <= quo[VBits-1:0];
                PhSlow:  slow_reg <= quo[VBits-1:0];
                default: signal_value <= $signed(quo[VBits-1:0] - Bias);
            endcase
        end
    end

    // macd formed right as the slow EMA finishes; mv[0] feeds the chain on the same edge
    assign macd_new   = fast_reg - quo[VBits-1:0];
    assign macd_value = $signed(fast_reg - slow_reg);
endmodule

### sv/msf_checker.sv
module msf_checker
    import msf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("out_valid dropped");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second request taken at once");
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind macd_signal_filter msf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready)
);
